FILE: rtl/hctt_pkg.sv
`timescale 1ns / 1ps

package hctt_pkg;

  // Event codes carried on the input channel
  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_UPDATE  = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CANCEL  = 3'd3,
    EV_RESET   = 3'd4
  } kind_e;

  // Effect codes reported with each result
  typedef enum logic [2:0] {
    FX_NONE     = 3'd0,
    FX_ARMED    = 3'd1,
    FX_PROGRESS = 3'd2,
    FX_FIRE     = 3'd3,
    FX_RESET    = 3'd4
  } effect_e;

  // Hold time used when the register holds zero
  localparam logic [31:0] HOLD_DEFAULT_MS = 32'd2000;

  // Remaining time at or above this saturates the tenths display
  localparam logic [31:0] SAT_MS      = 32'd100000;
  localparam logic [9:0]  TENTHS_CAP  = 10'd999;
  localparam logic [6:0]  SECONDS_CAP = 7'd99;
  localparam logic [3:0]  DIGIT_CAP   = 4'd9;

  // Reciprocals for ms < 100000: ms/100 = (ms*TENTH_RECIP) >> 24,
  // ms/1000 = (ms*SEC_RECIP) >> 27, both exact over that range
  localparam logic [17:0] TENTH_RECIP = 18'd167773;
  localparam logic [17:0] SEC_RECIP   = 18'd134218;

endpackage

FILE: rtl/hold_to_confirm_timer.sv
`timescale 1ns / 1ps

// Each input transfer passes the state stage, then the display stage, to result valid.
// Throughput: one event per cycle unless out_stall_i holds the pipeline; the state update
// closes in the single state stage. Stalls propagate back through both stages; each stage
// holds its data while stalled. Reset: press time, armed and fired flags clear, hold time
// register returns to 2000 ms, both pipeline stages empty.
module hold_to_confirm_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 hold_time_we_i,
  input  logic [31:0]          hold_time_i,
  // event channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           kind_i,
  input  logic [31:0]          now_ms_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hctt_pkg::effect_e    effect_o,
  output logic [31:0]          remaining_ms_o,
  output logic [9:0]           remaining_tenths_o,
  output logic [6:0]           whole_seconds_o,
  output logic [3:0]           tenth_digit_o
);

  import hctt_pkg::*;

  // Configuration register
  logic [31:0] hold_time_q;
  logic [31:0] hold_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= HOLD_DEFAULT_MS;
    end else if (hold_time_we_i) begin
      hold_time_q <= hold_time_i;
    end
  end

  assign hold_eff = (hold_time_q == '0) ? HOLD_DEFAULT_MS : hold_time_q;

  // Pipeline handshake
  logic    st_valid_q;
  logic    st_ready;
  logic    out_ready;
  logic    in_xfer;
  logic    st_xfer;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign st_ready   = !st_valid_q || out_ready;
  assign in_stall_o = !st_ready;
  assign in_xfer    = in_valid_i && st_ready;
  assign st_xfer    = st_valid_q && out_ready;

  // Detector state
  logic [31:0] press_time_q, press_time_d;
  logic        armed_q, armed_d;
  logic        done_q, done_d;
  effect_e     fx_d;
  logic [31:0] elapsed_now;
  logic [31:0] elapsed_new;
  logic [31:0] ms_d;

  assign elapsed_now = now_ms_i - press_time_q;

  // Event decode and state update
  always_comb begin
    press_time_d = press_time_q;
    armed_d      = armed_q;
    done_d       = done_q;
    fx_d         = FX_NONE;
    unique case (kind_i) inside
      EV_PRESS: begin
        if (!armed_q && !done_q) begin
          press_time_d = now_ms_i;
          armed_d      = 1'b1;
          fx_d         = FX_ARMED;
        end
      end
      EV_UPDATE: begin
        if (armed_q && !done_q) begin
          if (elapsed_now >= hold_eff) begin
            done_d = 1'b1;
            fx_d   = FX_FIRE;
          end else begin
            fx_d = FX_PROGRESS;
          end
        end
      end
      EV_RELEASE, EV_CANCEL: begin
        if (armed_q || done_q) begin
          press_time_d = '0;
          armed_d      = 1'b0;
          done_d       = 1'b0;
          fx_d         = FX_RESET;
        end
      end
      EV_RESET: begin
        press_time_d = '0;
        armed_d      = 1'b0;
        done_d       = 1'b0;
        fx_d         = FX_RESET;
      end
      default: begin
      end
    endcase
  end

  // Time left, measured after the event is applied
  assign elapsed_new = now_ms_i - press_time_d;

  always_comb begin
    ms_d = '0;
    if (armed_d && !done_d && (elapsed_new < hold_eff)) begin
      ms_d = hold_eff - elapsed_new;
    end
  end

  // State stage
  effect_e     st_fx_q;
  logic [31:0] st_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q <= '0;
      armed_q      <= 1'b0;
      done_q       <= 1'b0;
      st_valid_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        press_time_q <= press_time_d;
        armed_q      <= armed_d;
        done_q       <= done_d;
      end
      if (st_ready) begin
        st_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      st_fx_q <= fx_d;
      st_ms_q <= ms_d;
    end
  end

  // Display fields: constant division by reciprocal multiply
  logic        sat;
  logic [16:0] ms_lo;
  logic [34:0] tenth_prod;
  logic [34:0] sec_prod;
  logic [9:0]  tenths_raw;
  logic [6:0]  secs_raw;
  logic [9:0]  secs_x10;
  logic [9:0]  digit_diff;
  logic [9:0]  tenths_d;
  logic [6:0]  secs_d;
  logic [3:0]  digit_d;

  assign sat        = (st_ms_q >= SAT_MS);
  assign ms_lo      = st_ms_q[16:0];
  assign tenth_prod = 35'(ms_lo) * 35'(TENTH_RECIP);
  assign sec_prod   = 35'(ms_lo) * 35'(SEC_RECIP);
  assign tenths_raw = tenth_prod[33:24];
  assign secs_raw   = sec_prod[33:27];
  assign secs_x10   = (10'(secs_raw) << 3) + (10'(secs_raw) << 1);
  assign digit_diff = tenths_raw - secs_x10;

  always_comb begin
    if (sat) begin
      tenths_d = TENTHS_CAP;
      secs_d   = SECONDS_CAP;
      digit_d  = DIGIT_CAP;
    end else begin
      tenths_d = tenths_raw;
      secs_d   = secs_raw;
      digit_d  = digit_diff[3:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready) begin
      out_valid_o <= st_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_xfer) begin
      effect_o           <= st_fx_q;
      remaining_ms_o     <= st_ms_q;
      remaining_tenths_o <= tenths_d;
      whole_seconds_o    <= secs_d;
      tenth_digit_o      <= digit_d;
    end
  end

  // Checks
  a_done_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> armed_q)
    else $error("fired flag set without armed flag");

  a_no_time_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (effect_o == FX_FIRE || effect_o == FX_RESET) |-> remaining_ms_o == '0)
    else $error("time left reported after fire or reset");

  a_digits_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (10'(whole_seconds_o) * 10'd10 + 10'(tenth_digit_o))
                    == remaining_tenths_o)
    else $error("display digits disagree with tenths");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> st_valid_q && out_valid_o)
    else $error("input stalled with room in the pipeline");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(press_time_q) && $stable(armed_q) && $stable(done_q))
    else $error("detector state changed without a transfer");

endmodule

FILE: tb/sv/hold_to_confirm_timer_tb.sv
`timescale 1ns / 1ps

module hold_to_confirm_timer_tb;
  import hctt_pkg::*;

  // Event codes the block must ignore
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // Latency from input transfer to result, plus margin
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    effect_e     effect;
    logic [31:0] ms;
    logic [9:0]  tenths;
    logic [6:0]  seconds;
    logic [3:0]  digit;
  } hold_result_t;

  // DUT ports
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        hold_time_we_i = 1'b0;
  logic [31:0] hold_time_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i         = '0;
  logic [31:0] now_ms_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  effect_e     effect_o;
  logic [31:0] remaining_ms_o;
  logic [9:0]  remaining_tenths_o;
  logic [6:0]  whole_seconds_o;
  logic [3:0]  tenth_digit_o;

  // Local copy of the timer state and hold register
  logic [31:0] hold_reg = HOLD_DEFAULT_MS;
  logic [31:0] press_ms = '0;
  logic        armed    = 1'b0;
  logic        fired    = 1'b0;

  hold_result_t pending_results[$];

  // Random gaps on the sender and stalls on the receiver
  bit idle_en = 1'b1;

  int unsigned n_events   = 0;
  int unsigned n_active   = 0;
  int unsigned n_fires    = 0;
  int unsigned n_results  = 0;
  int unsigned n_settings = 0;
  int unsigned mismatches = 0;

  hold_to_confirm_timer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .hold_time_we_i     (hold_time_we_i),
    .hold_time_i        (hold_time_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .effect_o           (effect_o),
    .remaining_ms_o     (remaining_ms_o),
    .remaining_tenths_o (remaining_tenths_o),
    .whole_seconds_o    (whole_seconds_o),
    .tenth_digit_o      (tenth_digit_o)
  );

  always #2 clk_i = ~clk_i;

  // Run limit
  initial begin
    #2_000_000;
    $display("hold_to_confirm_timer test failed");
    $finish;
  end

  // Hold time in force; zero selects the default
  function automatic logic [31:0] hold_in_force();
    return (hold_reg == '0) ? HOLD_DEFAULT_MS : hold_reg;
  endfunction

  // Apply one event to the local state and work out its result
  function automatic hold_result_t predict_event(input logic [2:0] kind,
                                                 input logic [31:0] now);
    hold_result_t res;
    logic [31:0]  eff;
    logic [31:0]  elapsed;
    logic [31:0]  tenths;
    eff        = hold_in_force();
    res        = '0;
    res.effect = FX_NONE;
    case (kind)
      EV_PRESS: begin
        if (!armed && !fired) begin
          press_ms   = now;
          armed      = 1'b1;
          res.effect = FX_ARMED;
        end
      end
      EV_UPDATE: begin
        if (armed && !fired) begin
          elapsed = now - press_ms;
          if (elapsed >= eff) begin
            fired      = 1'b1;
            res.effect = FX_FIRE;
          end else begin
            res.effect = FX_PROGRESS;
          end
        end
      end
      EV_RELEASE, EV_CANCEL: begin
        if (armed || fired) begin
          press_ms   = '0;
          armed      = 1'b0;
          fired      = 1'b0;
          res.effect = FX_RESET;
        end
      end
      EV_RESET: begin
        press_ms   = '0;
        armed      = 1'b0;
        fired      = 1'b0;
        res.effect = FX_RESET;
      end
      default: ;
    endcase

    // Time still to hold, measured after the event
    elapsed = now - press_ms;
    if (!armed || fired || elapsed >= eff) res.ms = '0;
    else res.ms = eff - elapsed;
    tenths = res.ms / 100;
    if (tenths > TENTHS_CAP) tenths = TENTHS_CAP;
    res.tenths  = tenths[9:0];
    res.seconds = 7'(tenths / 10);
    res.digit   = 4'(tenths % 10);
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Send one event and queue its expected result once the transfer happens
  task automatic send_event(input logic [2:0] kind, input logic [31:0] now);
    hold_result_t res;
    while (idle_en && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_event(kind, now);
    pending_results.push_back(res);
    n_events++;
    if (res.effect != FX_NONE) n_active++;
    if (res.effect == FX_FIRE) n_fires++;
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_hold(input logic [31:0] value);
    wait_idle();
    hold_time_i    <= value;
    hold_time_we_i <= 1'b1;
    @(posedge clk_i);
    hold_time_we_i <= 1'b0;
    hold_reg = value;
    n_settings++;
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < 14);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    hold_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (effect_o !== want.effect)
          flag_mismatch($sformatf("effect got %0d want %0d", effect_o, want.effect));
        if (remaining_ms_o !== want.ms)
          flag_mismatch($sformatf("remaining_ms got %0d want %0d", remaining_ms_o, want.ms));
        if (remaining_tenths_o !== want.tenths)
          flag_mismatch($sformatf("remaining_tenths got %0d want %0d",
                                  remaining_tenths_o, want.tenths));
        if (whole_seconds_o !== want.seconds)
          flag_mismatch($sformatf("whole_seconds got %0d want %0d",
                                  whole_seconds_o, want.seconds));
        if (tenth_digit_o !== want.digit)
          flag_mismatch($sformatf("tenth_digit got %0d want %0d", tenth_digit_o, want.digit));
      end
    end
  end

  // Events that must do nothing while idle, unused codes, reset event
  task automatic test_idle_events();
    send_event(EV_UPDATE, 32'h0000_0000);
    send_event(EV_RELEASE, 32'hFFFF_FFFF);
    send_event(EV_CANCEL, 32'h0000_0000);
    send_event(KIND_SPARE_5, 32'h0000_0001);
    send_event(KIND_SPARE_6, 32'h8000_0000);
    send_event(KIND_SPARE_7, 32'hFFFF_FFFF);
    send_event(EV_RESET, 32'h0000_0000);
  endtask

  // Default hold across the 32-bit wrap; repeated press and update after fire
  task automatic test_default_hold();
    send_event(EV_PRESS, 32'hFFFF_FF00);
    send_event(EV_PRESS, 32'h0000_0000);
    send_event(EV_UPDATE, 32'hFFFF_FF01);
    send_event(EV_UPDATE, 32'hFFFF_FF00 + 32'd1999);
    send_event(KIND_SPARE_7, 32'hFFFF_FF00 + 32'd10);
    send_event(EV_UPDATE, 32'hFFFF_FF00 + 32'd2000);
    send_event(EV_UPDATE, 32'hFFFF_FF00 + 32'd2500);
    send_event(EV_PRESS, 32'h0000_1000);
    send_event(EV_CANCEL, 32'h0000_1000);
    send_event(EV_PRESS, 32'h0000_0000);
    send_event(EV_RELEASE, 32'h0000_0005);
    send_event(EV_PRESS, 32'h0000_1234);
    send_event(EV_RESET, 32'h0000_1300);
  endtask

  // Tenths display around the saturation point and the digit boundaries
  task automatic test_tenths_display();
    write_hold(32'd100000);
    send_event(EV_PRESS, 32'd0);
    send_event(EV_UPDATE, 32'd0);
    send_event(EV_UPDATE, 32'd1);
    send_event(EV_UPDATE, 32'd100);
    send_event(EV_UPDATE, 32'd101);
    send_event(EV_UPDATE, 32'd99900);
    send_event(EV_UPDATE, 32'd99901);
    send_event(EV_UPDATE, 32'd100000);
    send_event(EV_RELEASE, 32'd100001);
  endtask

  // Smallest and largest hold times, then back to the default via zero
  task automatic test_hold_extremes();
    write_hold(32'd1);
    send_event(EV_PRESS, 32'd10);
    send_event(EV_UPDATE, 32'd10);
    send_event(EV_UPDATE, 32'd11);
    send_event(EV_RELEASE, 32'd12);
    write_hold(32'hFFFF_FFFF);
    send_event(EV_PRESS, 32'd0);
    send_event(EV_UPDATE, 32'd5);
    send_event(EV_UPDATE, 32'hFFFF_FFFE);
    send_event(EV_UPDATE, 32'hFFFF_FFFF);
    send_event(EV_CANCEL, 32'd0);
    write_hold(32'd0);
    send_event(EV_PRESS, 32'd0);
    send_event(EV_UPDATE, 32'd1999);
  endtask

  // New hold time applies to a press already in progress
  task automatic test_hold_change_while_armed();
    write_hold(32'd500);
    send_event(EV_UPDATE, 32'd499);
    send_event(EV_UPDATE, 32'd500);
    send_event(EV_RELEASE, 32'd501);
  endtask

  // Press, a few updates, then mostly an ending; some random events in between
  task automatic run_hold_sequences(input int unsigned target);
    int unsigned goal;
    logic [31:0] t0;
    logic [31:0] span;
    logic [31:0] eff;
    int          n_upd;
    goal = n_events + target;
    while (n_events < goal) begin
      if ($urandom_range(99) < 80) begin
        eff   = hold_in_force();
        t0    = $urandom();
        n_upd = $urandom_range(6, 1);
        send_event(EV_PRESS, t0);
        for (int i = 0; i < n_upd; i++) begin
          case ($urandom_range(5))
            0, 1: span = $urandom_range(eff - 1);
            2:    span = eff - 32'd1;
            3:    span = eff;
            4:    span = eff + $urandom_range(50);
            default: span = $urandom();
          endcase
          send_event(EV_UPDATE, t0 + span);
        end
        case ($urandom_range(9))
          0, 1, 2: send_event(EV_RELEASE, t0 + $urandom());
          3, 4, 5: send_event(EV_CANCEL, t0 + $urandom());
          6, 7:    send_event(EV_RESET, $urandom());
          default: ;  // leave it armed; later presses are ignored while it stays armed
        endcase
      end else begin
        send_event(3'($urandom_range(7)), $urandom());
      end
    end
  endtask

  // Random phases over several hold settings, one without any idling
  task automatic test_random_phases();
    write_hold(32'd0);
    run_hold_sequences(150);
    write_hold($urandom_range(5000, 1));
    run_hold_sequences(150);
    write_hold($urandom_range(200000, 90000));
    run_hold_sequences(100);
    write_hold($urandom());
    run_hold_sequences(100);
    idle_en = 1'b0;
    write_hold(HOLD_DEFAULT_MS);
    run_hold_sequences(150);
    idle_en = 1'b1;
    write_hold(32'hFFFF_FFFF);
    run_hold_sequences(50);
    write_hold($urandom_range(300, 1));
    run_hold_sequences(60);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_events();
    test_default_hold();
    test_tenths_display();
    test_hold_extremes();
    test_hold_change_while_armed();
    test_random_phases();
    wait_idle();

    $display("Covered %0d events (%0d with an effect, %0d fires), %0d results checked,",
             n_events, n_active, n_fires, n_results);
    $display("across %0d hold time writes including zero, one and all ones.", n_settings);
    if (mismatches == 0) begin
      $display("hold_to_confirm_timer test passed");
    end else begin
      $display("hold_to_confirm_timer test failed");
    end
    $finish;
  end

endmodule
